FILE: src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define VRR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define VRR_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  `VRR_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

FILE: src/vrr_pkg.sv
`default_nettype none

package vrr_pkg;

  // number formats
  localparam int CompW      = 20;
  localparam int FracW      = 16;
  localparam int EtaW       = 18;
  localparam int WideW      = 48;
  localparam int ProdW      = 2 * CompW + 1;
  localparam int RootW      = 18;
  localparam int SqrtInW    = 2 * RootW;
  localparam int SqrtStages = RootW;
  localparam int LatCycles  = 8 + SqrtStages + 2;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [WideW-1:0] wide_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic [2:0][CompW-1:0]   vec_t;

  localparam wide_t FxOne = {{(WideW-FracW-1){1'b0}}, 1'b1, {FracW{1'b0}}};
  localparam wide_t FxMax = {{(WideW-CompW+1){1'b0}}, {(CompW-1){1'b1}}};
  localparam wide_t FxMin = ~FxMax;

  typedef enum logic {
    ActReflect = 1'b0,
    ActRefract = 1'b1
  } action_e;

  typedef struct packed {
    action_e         action;
    comp_t           dir_x;
    comp_t           dir_y;
    comp_t           dir_z;
    comp_t           normal_x;
    comp_t           normal_y;
    comp_t           normal_z;
    logic [EtaW-1:0] eta_ratio;
  } req_t;

  typedef struct packed {
    comp_t out_x;
    comp_t out_y;
    comp_t out_z;
    logic  saturated;
  } rsp_t;

  typedef struct packed {
    logic  sat;
    comp_t val;
  } clamp_t;

  // sideband that rides along the square root
  typedef struct packed {
    action_e act;
    vec_t    perp;
    vec_t    nrm;
    vec_t    refl;
    logic    sat;
  } side_t;

  // saturate a wide value to the component range
  function automatic clamp_t sat_comp(input wide_t v);
    clamp_t c;
    if (v > FxMax) begin
      c.sat = 1'b1;
      c.val = FxMax[CompW-1:0];
    end else if (v < FxMin) begin
      c.sat = 1'b1;
      c.val = FxMin[CompW-1:0];
    end else begin
      c.sat = 1'b0;
      c.val = v[CompW-1:0];
    end
    return c;
  endfunction

  // drop fraction bits, ties toward plus infinity
  function automatic wide_t fx_round(input wide_t v);
    wide_t half;
    half = wide_t'(1) <<< (FracW - 1);
    return (v + half) >>> FracW;
  endfunction

endpackage

`default_nettype wire

FILE: src/vector_reflect_refract_unit.sv
// a request taken at a clock edge shows its result on done_o once it leaves the last stage
// throughput: one request per cycle, busy_o stays low, the pipeline never stalls
// the depth is set by the 18-stage bit-per-stage square root plus ten arithmetic stages
// reset clears all valid bits; no result is produced for requests in flight at reset
`default_nettype none

module vector_reflect_refract_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  vrr_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output vrr_pkg::rsp_t rsp_o
);
  import vrr_pkg::*;

  logic [7:0] vld_q;
  logic       accept;
  comp_t      d_in [3];
  comp_t      n_in [3];

  // stage 1: dot product terms
  action_e         act1_q;
  comp_t           d1_q [3];
  comp_t           n1_q [3];
  logic [EtaW-1:0] eta1_q;
  prod_t           p1_q [3];
  // stage 2: clamped dot product
  action_e         act2_q;
  comp_t           d2_q [3];
  comp_t           n2_q [3];
  logic [EtaW-1:0] eta2_q;
  comp_t           dot2_q;
  logic            sat2_q;
  // stage 3: normal scaled by dot or cosine
  action_e         act3_q;
  comp_t           d3_q [3];
  comp_t           n3_q [3];
  logic [EtaW-1:0] eta3_q;
  prod_t           m3_q [3];
  logic            sat3_q;
  // stage 4: reflection result or d + n*cos
  action_e         act4_q;
  comp_t           n4_q [3];
  logic [EtaW-1:0] eta4_q;
  comp_t           v4_q [3];
  logic            sat4_q;
  // stage 5: scale by eta
  action_e         act5_q;
  comp_t           n5_q [3];
  comp_t           v5_q [3];
  prod_t           q5_q [3];
  logic            sat5_q;
  // stage 6..8
  side_t           st6_q;
  side_t           st7_q;
  prod_t           sq7_q [3];
  side_t           st8_q;
  logic [CompW-2:0] mag8_q;
  // square root and its sideband
  side_t           side_q [SqrtStages];
  logic            sqrt_vld;
  logic [RootW-1:0] sqrt_root;
  // final stages
  side_t           sta_q;
  prod_t           ma_q [3];
  logic            vlda_q;
  logic            done_q;
  rsp_t            rsp_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign d_in[0] = req_i.dir_x;
  assign d_in[1] = req_i.dir_y;
  assign d_in[2] = req_i.dir_z;
  assign n_in[0] = req_i.normal_x;
  assign n_in[1] = req_i.normal_y;
  assign n_in[2] = req_i.normal_z;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vlda_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[6:0], accept};
      vlda_q <= sqrt_vld;
      done_q <= vlda_q;
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    act1_q <= req_i.action;
    eta1_q <= req_i.eta_ratio;
    for (int i = 0; i < 3; i++) begin
      d1_q[i] <= d_in[i];
      n1_q[i] <= n_in[i];
      p1_q[i] <= d_in[i] * n_in[i];
    end
  end

  // stage 2
  clamp_t dot_c;
  always_comb begin
    dot_c = sat_comp(fx_round(wide_t'(p1_q[0])) + fx_round(wide_t'(p1_q[1]))
                     + fx_round(wide_t'(p1_q[2])));
  end

  always_ff @(posedge clk_i) begin
    act2_q <= act1_q;
    eta2_q <= eta1_q;
    d2_q   <= d1_q;
    n2_q   <= n1_q;
    dot2_q <= dot_c.val;
    sat2_q <= dot_c.sat;
  end

  // stage 3: cosine is -dot limited to one
  wide_t                neg_dot;
  logic signed [CompW:0] mul_op;
  always_comb begin
    neg_dot = -wide_t'(dot2_q);
    if (neg_dot > FxOne) begin
      neg_dot = FxOne;
    end
    if (act2_q == ActRefract) begin
      mul_op = neg_dot[CompW:0];
    end else begin
      mul_op = (CompW+1)'(dot2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    act3_q <= act2_q;
    eta3_q <= eta2_q;
    d3_q   <= d2_q;
    n3_q   <= n2_q;
    sat3_q <= sat2_q;
    for (int i = 0; i < 3; i++) begin
      m3_q[i] <= n2_q[i] * mul_op;
    end
  end

  // stage 4
  clamp_t v_c [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (act3_q == ActRefract) begin
        v_c[i] = sat_comp(wide_t'(d3_q[i]) + fx_round(wide_t'(m3_q[i])));
      end else begin
        v_c[i] = sat_comp(wide_t'(d3_q[i]) - (fx_round(wide_t'(m3_q[i])) <<< 1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act4_q <= act3_q;
    eta4_q <= eta3_q;
    n4_q   <= n3_q;
    sat4_q <= sat3_q | v_c[0].sat | v_c[1].sat | v_c[2].sat;
    for (int i = 0; i < 3; i++) begin
      v4_q[i] <= v_c[i].val;
    end
  end

  // stage 5
  logic signed [EtaW:0] eta_s;
  assign eta_s = $signed({1'b0, eta4_q});

  always_ff @(posedge clk_i) begin
    act5_q <= act4_q;
    n5_q   <= n4_q;
    v5_q   <= v4_q;
    sat5_q <= sat4_q;
    for (int i = 0; i < 3; i++) begin
      q5_q[i] <= v4_q[i] * eta_s;
    end
  end

  // stage 6: perpendicular part
  clamp_t perp_c [3];
  side_t  st6_d;
  always_comb begin
    st6_d.act = act5_q;
    st6_d.sat = sat5_q;
    for (int i = 0; i < 3; i++) begin
      perp_c[i]      = sat_comp(fx_round(wide_t'(q5_q[i])));
      st6_d.perp[i]  = perp_c[i].val;
      st6_d.nrm[i]   = n5_q[i];
      st6_d.refl[i]  = v5_q[i];
      if (act5_q == ActRefract && perp_c[i].sat) begin
        st6_d.sat = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st6_q <= st6_d;
  end

  // stage 7: squared length terms
  always_ff @(posedge clk_i) begin
    st7_q <= st6_q;
    for (int i = 0; i < 3; i++) begin
      sq7_q[i] <= $signed(st6_q.perp[i]) * $signed(st6_q.perp[i]);
    end
  end

  // stage 8: |1 - |perp|^2| limited to the positive maximum
  wide_t mag;
  side_t st8_d;
  always_comb begin
    st8_d = st7_q;
    mag   = FxOne - (fx_round(wide_t'(sq7_q[0])) + fx_round(wide_t'(sq7_q[1]))
                     + fx_round(wide_t'(sq7_q[2])));
    if (mag < 0) begin
      mag = -mag;
    end
    if (mag > FxMax) begin
      mag = FxMax;
      if (st7_q.act == ActRefract) begin
        st8_d.sat = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st8_q  <= st8_d;
    mag8_q <= mag[CompW-2:0];
  end

  // square root of mag scaled by the fraction bits
  vrr_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vld_q[7]),
    .radicand_i (SqrtInW'({mag8_q, {FracW{1'b0}}})),
    .valid_o    (sqrt_vld),
    .root_o     (sqrt_root)
  );

  // sideband delay matched to the root
  always_ff @(posedge clk_i) begin
    side_q[0] <= st8_q;
    for (int k = 1; k < SqrtStages; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // stage a: normal scaled by root
  logic signed [RootW:0] root_s;
  assign root_s = $signed({1'b0, sqrt_root});

  always_ff @(posedge clk_i) begin
    sta_q <= side_q[SqrtStages-1];
    for (int i = 0; i < 3; i++) begin
      ma_q[i] <= $signed(side_q[SqrtStages-1].nrm[i]) * root_s;
    end
  end

  // stage b: final subtraction and result select
  clamp_t r_c [3];
  comp_t  res [3];
  logic   res_sat;
  always_comb begin
    res_sat = sta_q.sat;
    for (int i = 0; i < 3; i++) begin
      r_c[i] = sat_comp(wide_t'($signed(sta_q.perp[i])) - fx_round(wide_t'(ma_q[i])));
      if (sta_q.act == ActRefract) begin
        res[i] = r_c[i].val;
        if (r_c[i].sat) begin
          res_sat = 1'b1;
        end
      end else begin
        res[i] = $signed(sta_q.refl[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q.out_x     <= res[0];
    rsp_q.out_y     <= res[1];
    rsp_q.out_z     <= res[2];
    rsp_q.saturated <= res_sat;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

FILE: src/vrr_isqrt.sv
`default_nettype none

module vrr_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [vrr_pkg::SqrtInW-1:0] radicand_i,
  output logic                        valid_o,
  output logic [vrr_pkg::RootW-1:0]   root_o
);
  import vrr_pkg::*;

  logic [SqrtInW-1:0]    rem_q  [SqrtStages];
  logic [RootW-1:0]      root_q [SqrtStages];
  logic [SqrtStages-1:0] vld_q;

  // one result bit per stage, most significant first
  for (genvar g = 0; g < SqrtStages; g++) begin : g_stage
    localparam int Bit = SqrtStages - 1 - g;
    logic [SqrtInW-1:0] rem_in, trial, rem_d;
    logic [RootW-1:0]   root_in, root_d;
    logic               vld_in;

    if (g == 0) begin : g_first
      assign rem_in  = radicand_i;
      assign root_in = '0;
      assign vld_in  = valid_i;
    end else begin : g_rest
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign vld_in  = vld_q[g-1];
    end

    // remainder test against (root + bit)^2 - root^2
    always_comb begin
      trial  = (SqrtInW'(root_in) << (Bit + 1)) | (SqrtInW'(1) << (2 * Bit));
      rem_d  = rem_in;
      root_d = root_in;
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = root_in | (RootW'(1) << Bit);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= rem_d;
      root_q[g] <= root_d;
    end
  end

  assign valid_o = vld_q[SqrtStages-1];
  assign root_o  = root_q[SqrtStages-1];

endmodule

`default_nettype wire

FILE: src/vrr_checker.sv
`default_nettype none
`include "assert_macros.svh"

module vrr_sva (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start_i,
  input wire vrr_pkg::req_t req_i,
  input wire logic          busy_o,
  input wire logic          done_o,
  input wire vrr_pkg::rsp_t rsp_o
);
  import vrr_pkg::*;

  logic zero_refl;
  vec_t dir_in;
  vec_t dir_out;

  // reflect request with an all-zero normal
  assign zero_refl = (req_i.action == ActReflect) && (req_i.normal_x == '0) &&
                     (req_i.normal_y == '0) && (req_i.normal_z == '0);
  assign dir_in    = {req_i.dir_x, req_i.dir_y, req_i.dir_z};
  assign dir_out   = {rsp_o.out_x, rsp_o.out_y, rsp_o.out_z};

  // the unit never refuses a request
  `VRR_ASSERT_NEVER(busy_never_a, clk_i, rst_ni, busy_o, "busy raised")

  // every request gives a result on done_o
  `VRR_ASSERT(req_done_a, clk_i, rst_ni, start_i |-> ##LatCycles done_o, "result missing")

  // no result without a request
  `VRR_ASSERT(done_req_a, clk_i, rst_ni, done_o |-> $past(start_i, LatCycles), "spurious result")

  // reflection about a zero normal returns the direction unchanged
  `VRR_ASSERT(zero_normal_a, clk_i, rst_ni, (done_o && $past(zero_refl, LatCycles)) |-> (dir_out == $past(dir_in, LatCycles) && !rsp_o.saturated), "zero normal reflect wrong")

endmodule

bind vector_reflect_refract_unit vrr_sva u_vrr_sva (.*);

`default_nettype wire
